// ===== sv/dks_pkg.sv =====
package dks_pkg;

    // The store size must be a power of two: sample indices and store
    // addresses wrap by dropping their upper bits.
    localparam int STORE_WORDS = 32768;
    localparam int AW          = $clog2(STORE_WORDS);

    localparam int QDEPTH = 2;
    localparam int QPW    = $clog2(QDEPTH);

    localparam logic [31:0] CONST_BIT  = 32'h2000_0000;
    localparam logic [31:0] RATE_MASK  = 32'hc000_0000;
    localparam logic [31:0] COUNT_MASK = 32'h1fff_0000;
    localparam logic [31:0] HALF_BIT   = 32'h4000_0000;
    localparam logic [15:0] RB_MASK    = 16'h7c1f;
    localparam logic [15:0] G_MASK     = 16'h03e0;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_COLOR = 2'd1,
        OP_ALPHA = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_CONST = 2'd1,
        ACT_READ  = 2'd2
    } t_act;

    // How the two keys are blended: midpoint, or 3/4 weight on the first (A)
    // or the second (B) key read.
    typedef enum logic [1:0] {
        MIX_NONE = 2'd0,
        MIX_MID  = 2'd1,
        MIX_HI_A = 2'd2,
        MIX_HI_B = 2'd3
    } t_mix;

    // addr holds a word index for colour reads and store writes, and a byte
    // address for alpha reads.
    typedef struct packed {
        t_act        act;
        t_mix        mix;
        logic        alpha;
        logic [AW:0] addr;
        logic [15:0] data;
    } t_cmd;

endpackage

// ===== sv/dks_front.sv =====
module dks_front (
    input  logic [1:0]    i_op,
    input  logic [14:0]   i_store_addr,
    input  logic [15:0]   i_store_data,
    input  logic [31:0]   i_track_entry,
    input  logic [15:0]   i_frame,
    output logic          o_keep,
    output dks_pkg::t_cmd o_cmd
);
    import dks_pkg::*;

    t_op         op;
    logic [31:0] cnt_w;
    logic [12:0] cnt;
    logic [15:0] base;
    logic [15:0] k0;
    logic [15:0] q;
    logic [1:0]  m;
    logic        past;
    logic        alpha;
    t_mix        mix;
    logic [16:0] sum;

    always_comb begin
        op    = t_op'(i_op);
        cnt_w = i_track_entry & COUNT_MASK;
        cnt   = cnt_w[28:16];
        base  = i_track_entry[15:0];
        m     = i_frame[1:0];
        q     = {2'b00, i_frame[15:2]};
        past  = i_frame > {3'b000, cnt};
        alpha = (op == OP_ALPHA);
        k0    = i_frame;
        mix   = MIX_NONE;

        if ((i_track_entry & RATE_MASK) == '0) begin
            k0 = i_frame;
        end else if ((i_track_entry & HALF_BIT) != '0) begin
            if (!i_frame[0]) begin
                k0 = {1'b0, i_frame[15:1]};
            end else if (past) begin
                k0 = {4'b0000, cnt[12:1]} + 16'd1;
            end else begin
                k0  = {1'b0, i_frame[15:1]};
                mix = MIX_MID;
            end
        end else begin
            k0 = q;
            if (m != 2'd0) begin
                if (past) begin
                    k0 = {5'b00000, cnt[12:2]} + {14'd0, m};
                end else begin
                    case (m)
                        2'd2:    mix = MIX_MID;
                        2'd3:    mix = MIX_HI_B;
                        default: mix = MIX_HI_A;
                    endcase
                end
            end
        end

        // Alpha reads address bytes, colour reads address halfwords.
        if (alpha) begin
            sum = {1'b0, base} + {1'b0, k0};
        end else begin
            sum = {2'b00, base[15:1]} + {1'b0, k0};
        end

        o_keep       = 1'b1;
        o_cmd.act    = ACT_READ;
        o_cmd.mix    = mix;
        o_cmd.alpha  = alpha;
        o_cmd.addr   = alpha ? sum[AW:0] : {1'b0, sum[AW-1:0]};
        o_cmd.data   = i_store_data;

        case (op)
            OP_WRITE: begin
                o_cmd.act  = ACT_WRITE;
                o_cmd.mix  = MIX_NONE;
                o_cmd.addr = {1'b0, i_store_addr[AW-1:0]};
            end
            OP_COLOR, OP_ALPHA: begin
                if ((i_track_entry & CONST_BIT) != '0) begin
                    o_cmd.act  = ACT_CONST;
                    o_cmd.mix  = MIX_NONE;
                    o_cmd.data = base;
                end
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/dks_queue.sv =====
module dks_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dks_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output dks_pkg::t_cmd o_cmd,
    output logic          o_empty,
    output logic          o_full
);
    import dks_pkg::*;

    t_cmd           r_slot [QDEPTH];
    logic [QPW-1:0] r_wr_ptr;
    logic [QPW-1:0] r_rd_ptr;
    logic [QPW:0]   r_count;
    logic [QPW:0]   n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPW+1)'(QDEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == (QPW+1)'(QDEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule

// ===== sv/dks_back.sv =====
module dks_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dks_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    output logic [15:0]   o_sample_value
);
    import dks_pkg::*;

    typedef enum logic [1:0] {
        ST_FIRST  = 2'b01,
        ST_SECOND = 2'b10
    } t_phase;

    typedef struct packed {
        logic        last;
        logic        is_const;
        t_mix        mix;
        logic        alpha;
        logic        sel;
        logic [15:0] cval;
    } t_stage;

    function automatic logic [15:0] f_mid(input logic [15:0] a, input logic [15:0] b,
                                          input logic alpha);
        logic [16:0] s_all;
        logic [16:0] s_rb;
        logic [16:0] s_g;
        s_all = {1'b0, a} + {1'b0, b};
        s_rb  = {1'b0, a & RB_MASK} + {1'b0, b & RB_MASK};
        s_g   = {1'b0, a & G_MASK} + {1'b0, b & G_MASK};
        if (alpha) begin
            return s_all[16:1];
        end
        return (s_rb[16:1] & RB_MASK) | (s_g[16:1] & G_MASK);
    endfunction

    // Three quarters of hi plus one quarter of lo, per channel.
    function automatic logic [15:0] f_quarter(input logic [15:0] hi, input logic [15:0] lo,
                                              input logic alpha);
        logic [15:0] h_rb;
        logic [15:0] l_rb;
        logic [15:0] h_g;
        logic [15:0] l_g;
        logic [17:0] s_all;
        logic [17:0] s_rb;
        logic [17:0] s_g;
        h_rb  = hi & RB_MASK;
        l_rb  = lo & RB_MASK;
        h_g   = hi & G_MASK;
        l_g   = lo & G_MASK;
        s_all = {1'b0, hi, 1'b0} + {2'b00, hi} + {2'b00, lo};
        s_rb  = {1'b0, h_rb, 1'b0} + {2'b00, h_rb} + {2'b00, l_rb};
        s_g   = {1'b0, h_g, 1'b0} + {2'b00, h_g} + {2'b00, l_g};
        if (alpha) begin
            return s_all[17:2];
        end
        return (s_rb[17:2] & RB_MASK) | (s_g[17:2] & G_MASK);
    endfunction

    logic [15:0] r_mem [STORE_WORDS];
    logic [15:0] r_rdata;

    t_phase      r_phase;
    t_phase      n_phase;
    logic [AW:0] r_addr1;
    t_mix        r_mix2;
    logic        r_alpha2;

    logic        r_y_valid;
    t_stage      r_y;
    logic [15:0] r_a;

    logic          rd_en;
    logic          wr_en;
    logic          y_valid;
    t_stage        y_next;
    logic [AW:0]   addr;
    logic          alpha;
    logic [AW-1:0] mem_addr;
    logic [AW:0]   addr_next;
    logic [15:0]   sample;
    logic [15:0]   result;

    // Issue stage: at most one store access a cycle, either a new command
    // from the queue or the second key read of an interpolated sample.
    always_comb begin
        o_pop   = (r_phase == ST_FIRST) && !i_empty;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        y_valid = 1'b0;
        n_phase = ST_FIRST;
        addr    = i_cmd.addr;
        alpha   = i_cmd.alpha;

        y_next.last     = 1'b1;
        y_next.is_const = 1'b0;
        y_next.mix      = i_cmd.mix;
        y_next.alpha    = i_cmd.alpha;
        y_next.cval     = i_cmd.data;

        if (r_phase == ST_SECOND) begin
            rd_en        = 1'b1;
            y_valid      = 1'b1;
            addr         = r_addr1;
            alpha        = r_alpha2;
            y_next.mix   = r_mix2;
            y_next.alpha = r_alpha2;
        end else if (o_pop) begin
            case (i_cmd.act)
                ACT_WRITE: begin
                    wr_en = 1'b1;
                end
                ACT_CONST: begin
                    y_valid         = 1'b1;
                    y_next.is_const = 1'b1;
                end
                ACT_READ: begin
                    rd_en       = 1'b1;
                    y_valid     = 1'b1;
                    y_next.last = (i_cmd.mix == MIX_NONE);
                    if (i_cmd.mix != MIX_NONE) begin
                        n_phase = ST_SECOND;
                    end
                end
                default: begin
                    y_valid = 1'b0;
                end
            endcase
        end

        y_next.sel = addr[0];
        mem_addr   = alpha ? addr[AW:1] : addr[AW-1:0];
        if (alpha) begin
            addr_next = addr + 1'b1;
        end else begin
            addr_next = {1'b0, addr[AW-1:0] + 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[mem_addr] <= i_cmd.data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // Return stage: the first key is held in r_a until the second arrives.
    always_comb begin
        if (r_y.alpha) begin
            sample = {8'h00, r_y.sel ? r_rdata[15:8] : r_rdata[7:0]};
        end else begin
            sample = r_rdata;
        end

        case (r_y.mix)
            MIX_MID:  result = f_mid(r_a, sample, r_y.alpha);
            MIX_HI_A: result = f_quarter(r_a, sample, r_y.alpha);
            MIX_HI_B: result = f_quarter(sample, r_a, r_y.alpha);
            default:  result = sample;
        endcase
        if (r_y.is_const) begin
            result = r_y.cval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ST_FIRST;
            r_y_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_y_valid <= y_valid;
            o_valid   <= r_y_valid && r_y.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y <= y_next;
        if (n_phase == ST_SECOND) begin
            r_addr1  <= addr_next;
            r_mix2   <= i_cmd.mix;
            r_alpha2 <= i_cmd.alpha;
        end
        if (r_y_valid && !r_y.last) begin
            r_a <= sample;
        end
        if (r_y_valid && r_y.last) begin
            o_sample_value <= result;
        end
    end

    a_second_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ST_SECOND |=> r_phase == ST_FIRST)
        else $error("second key read repeated");

    a_second_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ST_SECOND |-> $past(o_pop))
        else $error("second key read without a popped command");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_y_valid && r_y.last) |=> o_valid)
        else $error("finished sample lost before the output register");

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && wr_en))
        else $error("store read and written in the same cycle");

endmodule

// ===== sv/decimated_keyframe_sampler_core.sv =====
// Channel   Direction  Ports                                         Handshake
// command   in         i_op i_store_addr i_store_data                start && !busy
//                      i_track_entry i_frame
// result    out        o_sample_value                                o_valid, one cycle
//
// Writes, constants and direct reads are issued back to back; an
// interpolated sample holds the issue stage for its second key read, as
// both keys come from the one single-port store. busy is high while the
// two-entry command queue is full. Reset is synchronous and active low;
// the store itself is not cleared. The receiver cannot stall, so results
// are never held back.
module decimated_keyframe_sampler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [14:0] i_store_addr,
    input  logic [15:0] i_store_data,
    input  logic [31:0] i_track_entry,
    input  logic [15:0] i_frame,
    output logic        o_valid,
    output logic [15:0] o_sample_value
);
    import dks_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic keep;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    assign busy = q_full;
    assign push = start && !q_full && keep;

    dks_front u_front (
        .i_op          (i_op),
        .i_store_addr  (i_store_addr),
        .i_store_data  (i_store_data),
        .i_track_entry (i_track_entry),
        .i_frame       (i_frame),
        .o_keep        (keep),
        .o_cmd         (front_cmd)
    );

    dks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dks_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (queue_cmd),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_sample_value (o_sample_value)
    );

endmodule

// ===== verif/tb.sv =====
module tb;
    import dks_pkg::*;

    localparam int N_ITEMS     = 1800;
    localparam int CALM_TAIL   = 200;
    localparam int DRAIN_EVERY = 500;
    localparam int STALL_LIMIT = 1000;
    localparam int N_CUES      = 25;

    typedef struct packed {
        t_op         op;
        logic [14:0] addr;
        logic [15:0] data;
        logic [31:0] entry;
        logic [15:0] frame;
        logic        typed;
        logic [15:0] value;
    } t_cue_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [14:0] i_store_addr;
    logic [15:0] i_store_data;
    logic [31:0] i_track_entry;
    logic [15:0] i_frame;
    logic        o_valid;
    logic [15:0] o_sample_value;

    logic [15:0] store_copy   [STORE_WORDS];
    bit          word_written [STORE_WORDS];
    logic [15:0] expected_samples [$];

    int n_items;
    int n_writes;
    int n_samples;
    int n_ignored;
    int n_checked;
    int fail_count;
    int stall_cycles;

    // Words 0..3 and the last word are loaded first so that the rows with a
    // typed value can be read off directly.
    t_cue_row directed_cues [N_CUES] = '{
        '{OP_WRITE, 15'h0000, 16'hffff, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{OP_WRITE, 15'h0001, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{OP_WRITE, 15'h0002, 16'h7c00, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{OP_WRITE, 15'h0003, 16'h03e0, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{OP_WRITE, 15'h7fff, 16'h1234, 32'hffff_ffff, 16'hffff, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h2000_abcd, 16'hffff, 1'b1, 16'habcd},
        '{OP_ALPHA, 15'h7fff, 16'hffff, 32'hffff_ffff, 16'h0000, 1'b1, 16'hffff},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1, 16'hffff},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h0000_0003, 16'h0001, 1'b1, 16'h7c00},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h0000_0000, 16'hffff, 1'b1, 16'h1234},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h0000_ffff, 16'h0001, 1'b1, 16'hffff},
        '{OP_ALPHA, 15'h0000, 16'h0000, 32'h0000_0006, 16'h0000, 1'b1, 16'h00e0},
        '{OP_ALPHA, 15'h0000, 16'h0000, 32'h0000_0006, 16'h0001, 1'b1, 16'h0003},
        '{OP_ALPHA, 15'h0000, 16'h0000, 32'h0000_ffff, 16'h0001, 1'b1, 16'h00ff},
        '{OP_NONE,  15'h7fff, 16'hffff, 32'hffff_ffff, 16'hffff, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h4001_0000, 16'h0001, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h4000_0000, 16'h0003, 1'b1, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'hc003_0004, 16'h0001, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h8003_0004, 16'h0001, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h8003_0004, 16'h0002, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h8003_0004, 16'h0003, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h8000_0004, 16'h0001, 1'b1, 16'h03e0},
        '{OP_ALPHA, 15'h0000, 16'h0000, 32'h4001_0006, 16'h0001, 1'b0, 16'h0000},
        '{OP_ALPHA, 15'h0000, 16'h0000, 32'h8003_0006, 16'h0003, 1'b0, 16'h0000},
        '{OP_COLOR, 15'h0000, 16'h0000, 32'h9fff_0000, 16'hffff, 1'b0, 16'h0000}
    };

    decimated_keyframe_sampler_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_store_addr   (i_store_addr),
        .i_store_data   (i_store_data),
        .i_track_entry  (i_track_entry),
        .i_frame        (i_frame),
        .o_valid        (o_valid),
        .o_sample_value (o_sample_value)
    );

    always #5 i_clk = ~i_clk;

    // Store address of key k: a word index for colour, a byte address for alpha.
    function automatic logic [AW:0] key_addr(bit alpha, logic [15:0] base, logic [31:0] k);
        logic [31:0] sum;
        sum = alpha ? (32'(base) + k) : (32'(base[15:1]) + k);
        return sum[AW:0];
    endfunction

    function automatic logic [AW-1:0] key_word(bit alpha, logic [AW:0] a);
        return alpha ? a[AW:1] : a[AW-1:0];
    endfunction

    function automatic logic [15:0] read_key(bit alpha, logic [15:0] base, logic [31:0] k);
        logic [AW:0] a;
        logic [15:0] w;
        a = key_addr(alpha, base, k);
        w = store_copy[key_word(alpha, a)];
        if (!alpha)
            return w;
        return a[0] ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
    endfunction

    // Works out which key the frame lands on and how it is blended with the
    // key after it. Off-key frames beyond the count read one unblended key.
    function automatic void plan_keys(logic [31:0] entry, logic [15:0] f,
                                      output t_mix mix, output logic [31:0] ka);
        logic [12:0] cnt;
        logic [1:0]  m;
        cnt = entry[28:16];
        m   = f[1:0];
        mix = MIX_NONE;
        if (entry[31:30] == 2'b00) begin
            ka = 32'(f);
        end else if (entry[30]) begin
            if (!f[0]) begin
                ka = 32'(f >> 1);
            end else if (f > 16'(cnt)) begin
                ka = 32'(cnt >> 1) + 32'd1;
            end else begin
                ka  = 32'(f >> 1);
                mix = MIX_MID;
            end
        end else begin
            if (m == 2'd0) begin
                ka = 32'(f >> 2);
            end else if (f > 16'(cnt)) begin
                ka = 32'(cnt >> 2) + 32'(m);
            end else begin
                ka = 32'(f >> 2);
                if (m == 2'd2)
                    mix = MIX_MID;
                else if (m == 2'd1)
                    mix = MIX_HI_A;
                else
                    mix = MIX_HI_B;
            end
        end
    endfunction

    function automatic logic [15:0] blend(bit alpha, t_mix mix, logic [15:0] a, logic [15:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [31:0] rb;
        logic [31:0] g;
        if (mix == MIX_MID) begin
            if (alpha)
                return 16'((32'(a) + 32'(b)) >> 1);
            rb = ((32'(a & RB_MASK) + 32'(b & RB_MASK)) >> 1) & 32'(RB_MASK);
            g  = ((32'(a & G_MASK) + 32'(b & G_MASK)) >> 1) & 32'(G_MASK);
            return 16'(rb | g);
        end
        hi = (mix == MIX_HI_A) ? 32'(a) : 32'(b);
        lo = (mix == MIX_HI_A) ? 32'(b) : 32'(a);
        if (alpha)
            return 16'((hi * 3 + lo) >> 2);
        rb = (((hi & 32'(RB_MASK)) * 3 + (lo & 32'(RB_MASK))) >> 2) & 32'(RB_MASK);
        g  = (((hi & 32'(G_MASK)) * 3 + (lo & 32'(G_MASK))) >> 2) & 32'(G_MASK);
        return 16'(rb | g);
    endfunction

    function automatic logic [15:0] predict_sample(bit alpha, logic [31:0] entry, logic [15:0] f);
        t_mix        mix;
        logic [31:0] ka;
        logic [15:0] va;
        if ((entry & CONST_BIT) != 32'd0)
            return entry[15:0];
        plan_keys(entry, f, mix, ka);
        va = read_key(alpha, entry[15:0], ka);
        if (mix == MIX_NONE)
            return va;
        return blend(alpha, mix, va, read_key(alpha, entry[15:0], ka + 32'd1));
    endfunction

    // One transaction: hold start until the block takes it, then update the
    // store copy, queue the sample it will return, or count an unused op.
    task automatic send_command(t_cue_row r);
        start         <= 1'b1;
        i_op          <= r.op;
        i_store_addr  <= r.addr;
        i_store_data  <= r.data;
        i_track_entry <= r.entry;
        i_frame       <= r.frame;
        do @(posedge i_clk); while (busy !== 1'b0);
        case (r.op)
            OP_WRITE: begin
                store_copy[r.addr]   = r.data;
                word_written[r.addr] = 1'b1;
                n_items++;
                n_writes++;
            end
            OP_COLOR, OP_ALPHA: begin
                expected_samples.push_back(r.typed ? r.value
                    : predict_sample(r.op == OP_ALPHA, r.entry, r.frame));
                n_items++;
                n_samples++;
            end
            default: n_ignored++;
        endcase
    endtask

    // Keys that were never written are loaded with random words first, so no
    // sample ever reads an undefined store word.
    task automatic issue(t_cue_row r);
        t_mix          mix;
        logic [31:0]   ka;
        logic [AW-1:0] w;
        bit            alpha;
        t_cue_row      fill;
        alpha = (r.op == OP_ALPHA);
        if ((r.op == OP_COLOR || r.op == OP_ALPHA) && !r.entry[29]) begin
            plan_keys(r.entry, r.frame, mix, ka);
            for (int i = 0; i < 2; i++) begin
                if (i == 0 || mix != MIX_NONE) begin
                    w = key_word(alpha, key_addr(alpha, r.entry[15:0], ka + 32'(i)));
                    if (!word_written[w]) begin
                        fill = '{OP_WRITE, w, 16'($urandom), 32'($urandom),
                                 16'($urandom), 1'b0, 16'h0000};
                        send_command(fill);
                    end
                end
            end
        end
        send_command(r);
    endtask

    task automatic random_command();
        t_cue_row    r;
        int          pick;
        logic [12:0] cnt;
        pick    = $urandom_range(0, 99);
        r.addr  = ($urandom_range(0, 1) == 0) ? 15'($urandom) : 15'($urandom_range(0, 200));
        r.data  = 16'($urandom);
        r.entry = $urandom;
        r.frame = 16'($urandom);
        r.typed = 1'b0;
        r.value = 16'h0000;
        if (pick < 15) begin
            r.op = OP_WRITE;
        end else if (pick < 17) begin
            r.op = OP_NONE;
        end else begin
            if (pick < 58)
                r.op = OP_COLOR;
            else
                r.op = OP_ALPHA;
            case ($urandom_range(0, 9))
                0:       r.entry[31:29] = {2'($urandom), 1'b1};
                1, 2:    r.entry[31:29] = 3'b000;
                3, 4, 5: r.entry[31:29] = 3'b010;
                6, 7, 8: r.entry[31:29] = 3'b100;
                default: r.entry[31:29] = 3'b110;
            endcase
            cnt = ($urandom_range(0, 3) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40));
            r.entry[28:16] = cnt;
            if ($urandom_range(0, 2) != 0)
                r.entry[15:0] = 16'($urandom_range(0, 127));
            // Most frames fall around the key count so that interpolation and
            // the tail clamp are both reached often.
            if ($urandom_range(0, 4) != 0)
                r.frame = 16'($urandom_range(0, int'(cnt) + 8));
        end
        issue(r);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_samples.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        logic [15:0] want;
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (o_valid) begin
                if (expected_samples.size() == 0) begin
                    $error("unexpected result: sample_value %h", o_sample_value);
                    fail_count++;
                end else begin
                    want = expected_samples.pop_front();
                    n_checked++;
                    if (o_sample_value !== want) begin
                        $error("sample_value mismatch: expected %h, actual %h",
                               want, o_sample_value);
                        fail_count++;
                    end
                end
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        bit idle_on;
        int next_drain;
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_op          <= OP_NONE;
        i_store_addr  <= '0;
        i_store_data  <= '0;
        i_track_entry <= '0;
        i_frame       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cues[i])
            issue(directed_cues[i]);
        drain_results();

        idle_on    = 1'b1;
        next_drain = DRAIN_EVERY;
        while (n_items < N_ITEMS) begin
            if ($urandom_range(0, 39) == 0)
                idle_on = !idle_on;
            if (n_items >= next_drain) begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end else if (idle_on && n_items < N_ITEMS - CALM_TAIL
                         && $urandom_range(0, 4) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            random_command();
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d store writes and %0d colour/alpha samples, %0d unused-op transactions.",
                 n_writes, n_samples, n_ignored);
        $display("Checked %0d sample values against the predicted ones.", n_checked);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
